// ----- hdl/sact_pkg.sv -----
// ============================================================================
// sact_pkg
// Types and constants shared by the cache tag and replacement engine.
// ============================================================================
package sact_pkg;

    localparam int REQ_BITS   = 1;
    localparam int BLK_BITS   = 26;
    localparam int OTAG_BITS  = 20;
    localparam int OWAY_BITS  = 2;
    localparam int CNT_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED   = 1'd1;

    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_FIFO   = 2'd2;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic                 req_type;
        logic [BLK_BITS-1:0]  block_index;
        logic [OTAG_BITS-1:0] tag;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [OWAY_BITS-1:0] way;
        logic                 victim_valid;
        logic [OTAG_BITS-1:0] victim_tag;
        logic [CNT_BITS-1:0]  event_count;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOK,
        ST_OUT
    } t_state;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

// ----- hdl/set_assoc_cache_tag_policy_top.sv -----
// ============================================================================
// set_assoc_cache_tag_policy_top
// Tag compare, replacement choice and event counters of a set-associative
// cache; all per-set state lives in one RAM row per set.
// ============================================================================
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------
//  req      | in        | i_req_valid/o_req_stall | sact_pkg::t_req
//  rsp      | out       | o_rsp_valid/i_rsp_stall | sact_pkg::t_rsp
//  cfg      | in        | i_cfg_valid/o_cfg_ready | index + data
//
//  An access passes through the RAM read of the set row, compare and write
//  back, then the result register. After reset a clearing pass sweeps all
//  SETS rows of the row RAM, during which no transfer is taken on req
//  (configuration is accepted). Configuration is held off in the compare
//  cycle, where the LFSR may step. The result register holds while
//  i_rsp_stall is high; the next request is taken only once the previous
//  result has been transferred.
module set_assoc_cache_tag_policy_top #(
    parameter int SETS     = 64,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    output logic                                  o_req_stall,
    input  sact_pkg::t_req                        i_req,
    output logic                                  o_rsp_valid,
    input  logic                                  i_rsp_stall,
    output sact_pkg::t_rsp                        o_rsp,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sact_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [sact_pkg::CFG_DAT_BITS-1:0]     i_cfg_data
);
    import sact_pkg::*;

    localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    // one row: per way valid, tag, rank; then fifo pointer
    localparam int WAY_W     = 1 + TAG_BITS + WAY_BITS;
    localparam int ROW_W     = WAYS * WAY_W + WAY_BITS;

    t_state r_state, n_state;
    logic [SET_BITS-1:0] r_clr, r_set;
    logic [1:0]          r_policy;
    logic [15:0]         r_lfsr;
    logic [CNT_BITS-1:0] r_cnt [4];
    t_req                r_req;
    t_rsp                r_rsp;

    logic                ram_we;
    logic [SET_BITS-1:0] ram_addr;
    logic [ROW_W-1:0]    ram_wdata, ram_rdata;

    sact_ram #(.WIDTH(ROW_W), .DEPTH(1 << SET_BITS)) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // reset row: all lines invalid, rank equal to way, pointer zero
    logic [ROW_W-1:0] clr_row;
    always_comb begin
        clr_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            clr_row[w*WAY_W +: WAY_BITS] = WAY_BITS'(w);
        end
    end

    logic req_acc, rsp_acc;
    assign req_acc = i_req_valid && !o_req_stall;
    assign rsp_acc = o_rsp_valid && !i_rsp_stall;
    assign o_req_stall = (r_state != ST_IDLE);
    assign o_rsp_valid = (r_state == ST_OUT);
    assign o_cfg_ready = (r_state != ST_LOOK);
    assign o_rsp = r_rsp;

    logic [SET_BITS-1:0] req_set;
    assign req_set = (SETS > 1) ? SET_BITS'(i_req.block_index % SETS) : '0;

    // ---- lookup on the row read back from RAM ----
    logic [TAG_BITS-1:0] ltag;
    logic                hit, have_empty, vv;
    logic [WAY_BITS-1:0] hway, eway, lway, way, rway;
    logic [WAY_BITS-1:0] fptr;
    logic [WAY_BITS-1:0] old_rank;
    logic [TAG_BITS-1:0] vtag;
    logic [15:0]         lfsr_nx;
    logic [1:0]          cls;
    logic [CNT_BITS-1:0] cnt_nx;
    logic [ROW_W-1:0]    new_row;

    assign ltag    = TAG_BITS'(r_req.tag);
    assign fptr    = ram_rdata[WAYS*WAY_W +: WAY_BITS];
    assign lfsr_nx = lfsr_step(r_lfsr);
    assign rway    = WAY_BITS'(lfsr_nx % WAYS);

    always_comb begin
        hit = 1'b0; hway = '0; have_empty = 1'b0; eway = '0; lway = '0;
        for (int w = WAYS-1; w >= 0; w--) begin
            if (ram_rdata[w*WAY_W + WAY_BITS + TAG_BITS]) begin
                if (ram_rdata[w*WAY_W + WAY_BITS +: TAG_BITS] == ltag) begin
                    hit = 1'b1; hway = WAY_BITS'(w);
                end
            end else begin
                have_empty = 1'b1; eway = WAY_BITS'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (ram_rdata[w*WAY_W +: WAY_BITS] > ram_rdata[lway*WAY_W +: WAY_BITS]) begin
                lway = WAY_BITS'(w);
            end
        end
        if (hit) begin
            way = hway;
        end else if (r_policy == POL_FIFO) begin
            way = fptr;
        end else if (have_empty) begin
            way = eway;
        end else if (r_policy == POL_RANDOM) begin
            way = rway;
        end else begin
            way = lway;
        end
        vv       = !hit && ram_rdata[way*WAY_W + WAY_BITS + TAG_BITS];
        vtag     = vv ? ram_rdata[way*WAY_W + WAY_BITS +: TAG_BITS] : '0;
        old_rank = ram_rdata[way*WAY_W +: WAY_BITS];
        new_row  = ram_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (ram_rdata[w*WAY_W +: WAY_BITS] < old_rank) begin
                new_row[w*WAY_W +: WAY_BITS] = ram_rdata[w*WAY_W +: WAY_BITS] + 1'b1;
            end
        end
        new_row[way*WAY_W +: WAY_BITS] = '0;
        if (!hit) begin
            new_row[way*WAY_W + WAY_BITS + TAG_BITS] = 1'b1;
            new_row[way*WAY_W + WAY_BITS +: TAG_BITS] = ltag;
            if (r_policy == POL_FIFO) begin
                new_row[WAYS*WAY_W +: WAY_BITS] =
                    WAY_BITS'((32'(fptr) + 32'd1) % WAYS);
            end
        end
        cls    = {r_req.req_type, !hit};
        cnt_nx = (&r_cnt[cls]) ? r_cnt[cls] : r_cnt[cls] + 1'b1;
    end

    // ---- RAM port ----
    always_comb begin
        ram_we = 1'b0; ram_addr = req_set; ram_wdata = new_row;
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1; ram_addr = r_clr; ram_wdata = clr_row;
            end
            ST_LOOK: begin
                ram_we = 1'b1; ram_addr = r_set;
            end
            default: begin
                ram_addr = req_set;
            end
        endcase
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == SET_BITS'(SETS-1)) n_state = ST_IDLE;
            ST_IDLE:  if (req_acc) n_state = ST_LOOK;
            ST_LOOK:  n_state = ST_OUT;
            ST_OUT:   if (rsp_acc) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    logic cfg_wr;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_policy <= POL_LRU;
            r_lfsr   <= 16'd1;
            for (int i = 0; i < 4; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_LOOK) begin
                r_cnt[cls] <= cnt_nx;
                if (!hit && r_policy == POL_RANDOM && !have_empty) r_lfsr <= lfsr_nx;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_POLICY: r_policy <= i_cfg_data[1:0];
                    REG_SEED:   r_lfsr   <= (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req;
            r_set <= req_set;
        end
        if (r_state == ST_LOOK) begin
            r_rsp.hit          <= hit;
            r_rsp.way          <= OWAY_BITS'(way);
            r_rsp.victim_valid <= vv;
            r_rsp.victim_tag   <= OTAG_BITS'(vtag);
            r_rsp.event_count  <= cnt_nx;
        end
    end

    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !req_acc) else $error("request taken while busy");
    a_look_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> o_rsp_valid) else $error("no result after lookup");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("result dropped");
    a_hit_nov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.hit && o_rsp.victim_valid)) else $error("victim on hit");
endmodule

// ----- hdl/sact_ram.sv -----
// ============================================================================
// sact_ram
// Generic single-port synchronous RAM with registered read.
// ============================================================================
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
